[rtl/kmhm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kmhm_pkg;

   // Fixed field widths of the request, response and register port.
   localparam int FUNC_W      = 2;
   localparam int SYM_W       = 8;
   localparam int SYMBOL_BITS = 8;
   localparam int POS_W       = 32;
   localparam int DIST_W      = 7;
   localparam int COUNT_W     = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int PLEN_W      = 7;
   localparam int LIMIT_W     = 8;

   // Default pattern store depth.
   localparam int MAX_PATTERN_DEFAULT = 64;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TEXT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_NEW  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISMATCH_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ONLY     = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic issue;
      logic emit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic start;
      logic last_issue;
      logic hit;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/k_mismatch_hamming_matcher.sv]
// k-mismatch Hamming matcher.
// Requests arrive on req_ (valid/ready) with a function code and a symbol:
// load the next pattern symbol, push a text symbol, or start a new text.
// Registers (pattern length, mismatch limit, first-only mode) are written on
// the csr_ port, which is always ready; write them only while the block idles.
// Load and new-text requests are taken without leaving the idle state. A text
// symbol that completes an alignment starts a compare that reads one pattern
// symbol and one window symbol per cycle from two memories; a qualifying result
// goes to the response register after the last pair is counted. Other text
// symbols are also taken in the idle state. No request is taken while a compare
// runs, so the mismatch counter loop over the pattern sets the rate.
// A qualifying alignment is written to a response register on rsp_. If the
// receiver stalls, the block keeps taking requests until a new response is
// ready, then waits until the register frees up.
// Reset restores the register defaults and clears the counters, pointers and
// response valid; pattern memory contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module k_mismatch_hamming_matcher #(
   parameter int MAX_PATTERN = kmhm_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire [kmhm_pkg::FUNC_W-1:0]         req_func,
   input  wire [kmhm_pkg::SYM_W-1:0]          req_symbol,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [kmhm_pkg::POS_W-1:0]         rsp_position,
   output logic [kmhm_pkg::DIST_W-1:0]        rsp_distance,
   output logic [kmhm_pkg::COUNT_W-1:0]       rsp_report_count,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [kmhm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [kmhm_pkg::CSR_DATA_W-1:0]     csr_data
);

   kmhm_pkg::dp_cmd_type    cmd;
   kmhm_pkg::dp_status_type status;

   // Sequencer for the compare loop and response handoff.
   kmhm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Memories, counters and response register.
   kmhm_datapath #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_symbol       (req_symbol),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_distance     (rsp_distance),
      .rsp_report_count (rsp_report_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

endmodule

`default_nettype wire

[rtl/kmhm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module kmhm_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire kmhm_pkg::dp_status_type status,
   output kmhm_pkg::dp_cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_LAST = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.issue  = 1'b0;
      cmd.emit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && status.start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            // The last read pair is being counted in this cycle.
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.hit) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/kmhm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module kmhm_datapath #(
   parameter int MAX_PATTERN = kmhm_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire kmhm_pkg::dp_cmd_type               cmd,
   output kmhm_pkg::dp_status_type                 status,
   input  wire [kmhm_pkg::FUNC_W-1:0]              req_func,
   input  wire [kmhm_pkg::SYM_W-1:0]               req_symbol,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic [kmhm_pkg::POS_W-1:0]              rsp_position,
   output logic [kmhm_pkg::DIST_W-1:0]             rsp_distance,
   output logic [kmhm_pkg::COUNT_W-1:0]            rsp_report_count,
   input  wire                                     csr_valid,
   output logic                                    csr_ready,
   input  wire [kmhm_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire [kmhm_pkg::CSR_DATA_W-1:0]          csr_data
);

   localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int SUM_W = LEN_W + 1;
   localparam int SB    = kmhm_pkg::SYMBOL_BITS;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_PATTERN - 1);
   localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_PATTERN);
   localparam logic [31:0]      SAT32    = 32'hFFFF_FFFF;

   // Configuration registers.
   logic [kmhm_pkg::PLEN_W-1:0]  plen_ff;
   logic [kmhm_pkg::LIMIT_W-1:0] limit_ff;
   logic                         first_only_ff;

   // Pattern and text window memories.
   logic [SB-1:0] pat_mem [MAX_PATTERN];
   logic [SB-1:0] win_mem [MAX_PATTERN];

   // Control state.
   logic [LEN_W-1:0] load_ptr_ff;
   logic [PTR_W-1:0] wp_ff;
   logic [31:0]      seen_ff;
   logic [31:0]      reports_ff;
   logic             stopped_ff;
   logic             rd_valid_ff;
   logic             rsp_valid_ff;

   // Compare datapath registers.
   logic [PTR_W-1:0] j_ff;
   logic [PTR_W-1:0] wa_ff;
   logic [SB-1:0]    pat_q_ff;
   logic [SB-1:0]    win_q_ff;
   logic [LEN_W-1:0] acc_ff;

   // Response payload registers.
   logic [kmhm_pkg::POS_W-1:0]   pos_ff;
   logic [kmhm_pkg::DIST_W-1:0]  dist_ff;
   logic [kmhm_pkg::COUNT_W-1:0] count_ff;

   logic [SB-1:0]    sym;
   logic [LEN_W-1:0] m_len;
   logic [31:0]      seen_in;
   logic [31:0]      reports_in;
   logic [PTR_W-1:0] wp_in;
   logic [SUM_W-1:0] wpn_e;
   logic [SUM_W-1:0] m_e;
   logic [SUM_W-1:0] base_e;
   logic [PTR_W-1:0] wa_in;
   logic             is_text;
   logic             is_load;
   logic             is_new;

   assign csr_ready = 1'b1;
   assign sym       = req_symbol[SB-1:0];
   assign is_text   = cmd.accept && (req_func == kmhm_pkg::FUNC_TEXT);
   assign is_load   = cmd.accept && (req_func == kmhm_pkg::FUNC_LOAD);
   assign is_new    = cmd.accept && (req_func == kmhm_pkg::FUNC_NEW);

   // Active pattern length, clamped to 1 .. MAX_PATTERN.
   always_comb begin
      if (plen_ff == '0) begin
         m_len = LEN_W'(1);
      end else if (32'(plen_ff) > 32'(MAX_PATTERN)) begin
         m_len = LEN_MAX;
      end else begin
         m_len = LEN_W'(plen_ff);
      end
   end

   // Saturating counters and the window write pointer after a text symbol.
   assign seen_in    = (seen_ff == SAT32) ? seen_ff : seen_ff + 32'd1;
   assign reports_in = (reports_ff == SAT32) ? reports_ff : reports_ff + 32'd1;
   assign wp_in      = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
   assign wa_in      = (wa_ff == PTR_LAST) ? '0 : wa_ff + PTR_W'(1);

   // Oldest window entry of the alignment, in circular buffer order.
   always_comb begin
      wpn_e = SUM_W'(wp_in);
      m_e   = SUM_W'(m_len);
      if (wpn_e >= m_e) begin
         base_e = wpn_e - m_e;
      end else begin
         base_e = wpn_e + SUM_W'(MAX_PATTERN) - m_e;
      end
   end

   // Status toward the controller.
   always_comb begin
      status.start      = (req_func == kmhm_pkg::FUNC_TEXT) && !stopped_ff
                          && (seen_in >= 32'(m_len));
      status.last_issue = (LEN_W'(j_ff) == m_len - LEN_W'(1));
      status.hit        = limit_ff[kmhm_pkg::LIMIT_W-1]
                          || (32'(acc_ff) <= 32'(limit_ff[kmhm_pkg::LIMIT_W-2:0]));
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff       <= kmhm_pkg::PLEN_W'(1);
         limit_ff      <= '1;
         first_only_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            kmhm_pkg::CSR_PATTERN_LENGTH: plen_ff <= csr_data[kmhm_pkg::PLEN_W-1:0];
            kmhm_pkg::CSR_MISMATCH_LIMIT: limit_ff <= csr_data;
            kmhm_pkg::CSR_FIRST_ONLY:     first_only_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Pattern memory: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (is_load && (load_ptr_ff < LEN_MAX)) begin
         pat_mem[load_ptr_ff[PTR_W-1:0]] <= sym;
      end
      if (cmd.issue) begin
         pat_q_ff <= pat_mem[j_ff];
      end
   end

   // Text window memory, written as a circular buffer.
   always_ff @(posedge clock) begin
      if (is_text) begin
         win_mem[wp_ff] <= sym;
      end
      if (cmd.issue) begin
         win_q_ff <= win_mem[wa_ff];
      end
   end

   // Request bookkeeping and report state.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff <= '0;
         wp_ff       <= '0;
         seen_ff     <= '0;
         reports_ff  <= '0;
         stopped_ff  <= 1'b0;
      end else begin
         if (is_new) begin
            load_ptr_ff <= '0;
            seen_ff     <= '0;
            reports_ff  <= '0;
            stopped_ff  <= 1'b0;
         end
         if (is_load && (load_ptr_ff < LEN_MAX)) begin
            load_ptr_ff <= load_ptr_ff + LEN_W'(1);
         end
         if (is_text) begin
            wp_ff   <= wp_in;
            seen_ff <= seen_in;
         end
         if (cmd.emit) begin
            reports_ff <= reports_in;
            if (first_only_ff) begin
               stopped_ff <= 1'b1;
            end
         end
      end
   end

   // Mismatch count: one symbol pair per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (is_text) begin
         j_ff   <= '0;
         wa_ff  <= base_e[PTR_W-1:0];
         acc_ff <= '0;
      end else begin
         if (cmd.issue) begin
            j_ff  <= j_ff + PTR_W'(1);
            wa_ff <= wa_in;
         end
         if (rd_valid_ff && (pat_q_ff != win_q_ff)) begin
            acc_ff <= acc_ff + LEN_W'(1);
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pos_ff   <= (seen_ff == SAT32) ? SAT32 : seen_ff - 32'(m_len);
         dist_ff  <= (32'(acc_ff) > 32'd127) ? '1 : kmhm_pkg::DIST_W'(acc_ff);
         count_ff <= reports_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = pos_ff;
   assign rsp_distance     = dist_ff;
   assign rsp_report_count = count_ff;

endmodule

`default_nettype wire

[tb/kmhm_match_checker.sv]
`timescale 1ns / 1ps

// Watches the request, response and register channels of the matcher.
// Every accepted request updates a local copy of the matcher state, and any
// alignment that qualifies is queued as an expected report. Every accepted
// response is compared field by field with the oldest queued report.
module kmhm_match_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_ready,
   input  wire [kmhm_pkg::FUNC_W-1:0]         req_func,
   input  wire [kmhm_pkg::SYM_W-1:0]          req_symbol,
   input  wire                                rsp_valid,
   input  wire                                rsp_ready,
   input  wire [kmhm_pkg::POS_W-1:0]          rsp_position,
   input  wire [kmhm_pkg::DIST_W-1:0]         rsp_distance,
   input  wire [kmhm_pkg::COUNT_W-1:0]        rsp_report_count,
   input  wire                                csr_valid,
   input  wire                                csr_ready,
   input  wire [kmhm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [kmhm_pkg::CSR_DATA_W-1:0]     csr_data,
   output int                                 pending,
   output int                                 error_count
);
   import kmhm_pkg::*;

   localparam int          DEPTH       = MAX_PATTERN_DEFAULT;
   localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;
   localparam int          DIST_MAX    = 127;

   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [DIST_W-1:0]  distance;
      logic [COUNT_W-1:0] report_count;
   } match_report_type;

   // Local copies of the registers.
   logic [PLEN_W-1:0]         cfg_length;
   logic signed [LIMIT_W-1:0] cfg_limit;
   logic                      cfg_first_only;

   // Local copy of the matcher state. Window entry 0 holds the newest symbol.
   logic [SYM_W-1:0] pattern_mem [DEPTH];
   logic [SYM_W-1:0] window [DEPTH];
   int               load_ptr;
   logic [31:0]      seen_count;
   logic [31:0]      hit_count;
   logic             halted;

   match_report_type expected_reports[$];

   // Prints one line per mismatch and counts every one.
   task automatic flag_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // Starts a new text; the pattern contents are kept.
   task automatic clear_text();
      for (int i = 0; i < DEPTH; i++) begin
         window[i] = '0;
      end
      seen_count = '0;
      hit_count  = '0;
      halted     = 1'b0;
      load_ptr   = 0;
   endtask

   // Applies one request to the local state and queues the report it causes.
   task automatic predict_matches(input logic [FUNC_W-1:0] func,
                                  input logic [SYM_W-1:0] sym);
      int               m;
      int               mismatches;
      int               limit;
      match_report_type rep;
      case (func)
         FUNC_NEW: begin
            clear_text();
         end
         FUNC_LOAD: begin
            // The load pointer saturates, so extra pattern symbols are dropped.
            if (load_ptr < DEPTH) begin
               pattern_mem[load_ptr] = sym;
               load_ptr++;
            end
         end
         FUNC_TEXT: begin
            for (int i = DEPTH - 1; i > 0; i--) begin
               window[i] = window[i-1];
            end
            window[0] = sym;
            if (seen_count != COUNT_MAX) begin
               seen_count++;
            end
            // A length of zero acts as one, and anything above the depth as the depth.
            m = (cfg_length == 0) ? 1 : (cfg_length > DEPTH) ? DEPTH : int'(cfg_length);
            if (seen_count >= 32'(m) && !halted) begin
               mismatches = 0;
               for (int j = 0; j < m; j++) begin
                  if (window[m-1-j] != pattern_mem[j]) begin
                     mismatches++;
                  end
               end
               limit = cfg_limit;
               if (limit < 0 || mismatches <= limit) begin
                  if (hit_count != COUNT_MAX) begin
                     hit_count++;
                  end
                  if (cfg_first_only) begin
                     halted = 1'b1;
                  end
                  rep.position     = (seen_count == COUNT_MAX) ? COUNT_MAX
                                                               : seen_count - 32'(m);
                  rep.distance     = DIST_W'((mismatches > DIST_MAX) ? DIST_MAX
                                                                     : mismatches);
                  rep.report_count = hit_count;
                  expected_reports.push_back(rep);
               end
            end
         end
         default: begin
            // The unused function code changes nothing.
         end
      endcase
   endtask

   // Responses are checked before the request of the same edge is applied,
   // since a request can never produce its report in the cycle it is taken.
   always @(posedge clock) begin : watch_channels
      match_report_type want;
      if (reset) begin
         cfg_length     = 1;
         cfg_limit      = -1;
         cfg_first_only = 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            pattern_mem[i] = '0;
         end
         clear_text();
         expected_reports.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               flag_mismatch($sformatf("unexpected report: position %0d distance %0d count %0d",
                                       rsp_position, rsp_distance, rsp_report_count));
            end else begin
               want = expected_reports.pop_front();
               if (rsp_position !== want.position) begin
                  flag_mismatch($sformatf("position %0d, expected %0d",
                                          rsp_position, want.position));
               end
               if (rsp_distance !== want.distance) begin
                  flag_mismatch($sformatf("distance %0d, expected %0d",
                                          rsp_distance, want.distance));
               end
               if (rsp_report_count !== want.report_count) begin
                  flag_mismatch($sformatf("report count %0d, expected %0d",
                                          rsp_report_count, want.report_count));
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_matches(req_func, req_symbol);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LENGTH: cfg_length     = csr_data[PLEN_W-1:0];
               CSR_MISMATCH_LIMIT: cfg_limit      = csr_data[LIMIT_W-1:0];
               CSR_FIRST_ONLY:     cfg_first_only = csr_data[0];
               default: begin
                  // Writes to the unused index are dropped.
               end
            endcase
         end
      end
      pending <= expected_reports.size();
   end

endmodule

[tb/tb_k_mismatch_hamming_matcher.sv]
`timescale 1ns / 1ps

module tb_k_mismatch_hamming_matcher;
   import kmhm_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 8;
   localparam int TARGET_ITEMS   = 1250;
   localparam int DEPTH          = MAX_PATTERN_DEFAULT;
   localparam int DRAIN_CYCLES   = MAX_PATTERN_DEFAULT + 16;
   localparam int WATCHDOG_LIMIT = 2000;

   // Codes that the block defines no meaning for.
   localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED  = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [FUNC_W-1:0]     req_func;
   logic [SYM_W-1:0]      req_symbol;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [POS_W-1:0]      rsp_position;
   logic [DIST_W-1:0]     rsp_distance;
   logic [COUNT_W-1:0]    rsp_report_count;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int pending;
   int error_count;
   int idle_cycles;

   // Stimulus state: idling rates, and enough of the pattern bookkeeping to
   // make sure no alignment ever reads a pattern entry that was never loaded.
   int             send_idle_pct;
   int             recv_stall_pct;
   int             items_sent;
   int             load_ptr;
   int             written_depth;
   int             cur_m;
   int             alphabet_size;
   logic [SYM_W-1:0] alphabet [4];

   k_mismatch_hamming_matcher i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_symbol       (req_symbol),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_distance     (rsp_distance),
      .rsp_report_count (rsp_report_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   kmhm_match_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_symbol       (req_symbol),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_distance     (rsp_distance),
      .rsp_report_count (rsp_report_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .pending          (pending),
      .error_count      (error_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // The receiver stalls the response channel at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: ends the run if no channel moves anything for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Sends one request, with random idle cycles ahead of it, and waits for it
   // to be taken.
   task automatic send_request(input logic [FUNC_W-1:0] func, input logic [SYM_W-1:0] sym);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= func;
      req_symbol <= sym;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      case (func)
         FUNC_NEW: begin
            load_ptr = 0;
         end
         FUNC_LOAD: begin
            if (load_ptr < DEPTH) begin
               load_ptr++;
            end
            if (load_ptr > written_depth) begin
               written_depth = load_ptr;
            end
         end
         default: begin
         end
      endcase
      if (func != FUNC_UNUSED) begin
         items_sent++;
      end
   endtask

   // Holds the sender until every expected report has come back, then lets
   // any compare that reports nothing run out.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves valid high; the caller lowers it after the last write.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
   endtask

   // Writes every register once the block has gone idle.
   task automatic apply_config(input logic [CSR_DATA_W-1:0] len_data,
                               input logic [CSR_DATA_W-1:0] limit_data,
                               input logic first_data);
      wait_idle();
      write_register(CSR_UNUSED, CSR_DATA_W'($urandom_range(255)));
      write_register(CSR_PATTERN_LENGTH, len_data);
      write_register(CSR_MISMATCH_LIMIT, limit_data);
      write_register(CSR_FIRST_ONLY, {7'($urandom_range(127)), first_data});
      csr_valid <= 1'b0;
      cur_m = (len_data == 0) ? 1 : (len_data > DEPTH) ? DEPTH : int'(len_data);
   endtask

   // Symbols come from a small alphabet so that close matches are common;
   // an empty alphabet means full random bytes.
   function automatic logic [SYM_W-1:0] pick_symbol();
      if (alphabet_size == 0) begin
         return SYM_W'($urandom_range(255));
      end
      return alphabet[$urandom_range(alphabet_size - 1)];
   endfunction

   // One text: usually a new-text request, a pattern load, then a text stream
   // with a few loads and unused codes mixed in.
   task automatic run_text_sequence();
      int n_load;
      int n_text;
      if ($urandom_range(9) != 0) begin
         send_request(FUNC_NEW, SYM_W'($urandom_range(255)));
      end
      case ($urandom_range(5))
         0:       alphabet_size = 0;
         1:       alphabet_size = 1;
         2, 3:    alphabet_size = 2;
         default: alphabet_size = $urandom_range(3, 4);
      endcase
      for (int i = 0; i < 4; i++) begin
         alphabet[i] = SYM_W'($urandom_range(255));
      end
      // Enough pattern symbols must be in place before the first alignment.
      if (written_depth >= cur_m && $urandom_range(3) == 0) begin
         n_load = 0;
      end else if ($urandom_range(19) == 0) begin
         n_load = DEPTH + 3;
      end else begin
         n_load = $urandom_range(cur_m, cur_m + 2);
      end
      repeat (n_load) send_request(FUNC_LOAD, pick_symbol());
      n_text = $urandom_range(1, cur_m + 16);
      repeat (n_text) begin
         case ($urandom_range(19))
            0:       send_request(FUNC_UNUSED, SYM_W'($urandom_range(255)));
            1:       send_request(FUNC_LOAD, pick_symbol());
            default: send_request(FUNC_TEXT, pick_symbol());
         endcase
      end
   endtask

   initial begin
      int                    phase;
      logic [CSR_DATA_W-1:0] len_data;
      logic [CSR_DATA_W-1:0] limit_data;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_LOAD;
      req_symbol     = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_PATTERN_LENGTH;
      csr_data       = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      items_sent     = 0;
      load_ptr       = 0;
      written_depth  = 0;
      cur_m          = 1;
      alphabet_size  = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset registers: length one, every alignment reported.
      send_request(FUNC_UNUSED, 8'hFF);
      send_request(FUNC_LOAD, 8'h00);
      send_request(FUNC_LOAD, 8'hFF);
      send_request(FUNC_LOAD, 8'hA5);
      send_request(FUNC_TEXT, 8'h00);
      send_request(FUNC_TEXT, 8'hFF);
      send_request(FUNC_LOAD, 8'h5A);
      send_request(FUNC_NEW, 8'hFF);
      // The pattern survives a new text; a load during text replaces entry 0.
      send_request(FUNC_TEXT, 8'hFF);
      send_request(FUNC_LOAD, 8'hFF);
      send_request(FUNC_TEXT, 8'hFF);

      // Length zero acts as one; exact matches only, first hit only.
      apply_config(8'd0, 8'd0, 1'b1);
      send_request(FUNC_NEW, 8'h00);
      send_request(FUNC_TEXT, 8'h00);
      send_request(FUNC_TEXT, 8'hFF);
      send_request(FUNC_TEXT, 8'hFF);
      send_request(FUNC_NEW, 8'h00);
      send_request(FUNC_TEXT, 8'hFF);

      // Random phases rotate through the idling modes. The first two pin the
      // largest length and the limit extremes.
      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         if (phase == 0) begin
            len_data   = 8'd127;
            limit_data = 8'h80;
         end else if (phase == 1) begin
            len_data   = 8'(DEPTH);
            limit_data = 8'd127;
         end else begin
            case ($urandom_range(9))
               0:       len_data = 8'(DEPTH);
               1:       len_data = 8'd127;
               2:       len_data = 8'd0;
               3:       len_data = 8'd1;
               default: len_data = 8'($urandom_range(2, 8));
            endcase
            case ($urandom_range(7))
               0:       limit_data = 8'hFF;
               1:       limit_data = 8'h80;
               2:       limit_data = 8'd0;
               3:       limit_data = 8'(DEPTH);
               4:       limit_data = 8'd127;
               default: limit_data = 8'($urandom_range(1, 3));
            endcase
         end
         apply_config(len_data, limit_data, 1'($urandom_range(1)));
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 74;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 74;
            end
            default: begin
               send_idle_pct  = 17;
               recv_stall_pct = 17;
            end
         endcase
         repeat ($urandom_range(1, 3)) run_text_sequence();
         phase++;
      end

      wait_idle();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
